### design/dsgt_pkg.sv
// Package with the types and constants shared by the dial spin gesture toggle modules.
`default_nettype none

package dsgt_pkg;

    typedef enum logic [1:0] {
        CMD_DETENT     = 2'd0,
        CMD_TAP        = 2'd1,
        CMD_LONG_PRESS = 2'd2,
        CMD_CLEAR      = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        SPIN_NONE  = 2'd0,
        SPIN_RIGHT = 2'd1,
        SPIN_LEFT  = 2'd2
    } spin_t;

    typedef enum logic [1:0] {
        HAPTIC_NONE  = 2'd0,
        HAPTIC_CLICK = 2'd1,
        HAPTIC_FIRM  = 2'd2
    } haptic_t;

    localparam int unsigned CfgIndexWidth = 2;
    localparam int unsigned CfgDataWidth  = 16;

    localparam logic [CfgIndexWidth-1:0] CFG_DETENTS_PER_SPIN = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_GAP_LIMIT_MS     = 2'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_RESYNC_WINDOW_MS = 2'd2;

    localparam logic [3:0]  DETENTS_PER_SPIN_RESET = 4'd3;
    localparam logic [15:0] GAP_LIMIT_MS_RESET     = 16'd600;
    localparam logic [15:0] RESYNC_WINDOW_MS_RESET = 16'd2000;

    typedef struct packed {
        logic [3:0]  detents_per_spin;
        logic [15:0] gap_limit_ms;
        logic [15:0] resync_window_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic signed [4:0] detent_delta;
        logic [31:0]       now_ms;
        logic              link_accepts;
    } item_t;

    typedef struct packed {
        logic signed [4:0] detent_count;
        logic [31:0]       last_detent_time;
        spin_t             last_spin_direction;
        logic [31:0]       last_spin_time;
        logic              belief_on;
        logic [31:0]       start_time;
        logic              swallow_next_tap;
    } state_t;

    typedef struct packed {
        logic        toggle_sent;
        logic        believed_live;
        haptic_t     haptic_kind;
        spin_t       spin_seen;
        logic        resync_hit;
        logic [31:0] live_since_ms;
    } result_t;

endpackage

`default_nettype wire

### design/dsgt_step.sv
// Combinational next-state and result logic for one gesture event.
`default_nettype none

module dsgt_step (
    input  var dsgt_pkg::cfg_t    cfg,
    input  var dsgt_pkg::item_t   item,
    input  var dsgt_pkg::state_t  st,
    output dsgt_pkg::state_t      st_next,
    output dsgt_pkg::result_t     res
);
    import dsgt_pkg::*;

    logic signed [4:0] count;
    logic signed [4:0] delta;
    logic signed [4:0] count_base;
    logic signed [5:0] sum;
    logic signed [5:0] thr;
    logic [31:0]       detent_gap;
    logic [31:0]       spin_gap;
    logic              gap_hit;
    logic              reversal;
    logic              spin_right;
    logic              spin_left;
    spin_t             dir;
    logic              resync;
    logic              wants_toggle;

    assign count      = st.detent_count;
    assign delta      = item.detent_delta;
    assign detent_gap = item.now_ms - st.last_detent_time;
    assign spin_gap   = item.now_ms - st.last_spin_time;
    assign gap_hit    = detent_gap > {16'd0, cfg.gap_limit_ms};
    assign reversal   = ((count > 5'sd0) && (delta < 5'sd0)) ||
                        ((count < 5'sd0) && (delta > 5'sd0));
    assign count_base = (gap_hit || reversal) ? 5'sd0 : count;
    assign sum        = {count_base[4], count_base} + {delta[4], delta};
    assign thr        = (cfg.detents_per_spin == 4'd0) ? 6'sd1
                                                       : signed'({2'b00, cfg.detents_per_spin});
    assign spin_right = sum >= thr;
    assign spin_left  = sum <= -thr;
    assign dir        = spin_right ? SPIN_RIGHT : (spin_left ? SPIN_LEFT : SPIN_NONE);
    assign resync     = (dir != SPIN_NONE) && (dir == st.last_spin_direction) &&
                        (spin_gap < {16'd0, cfg.resync_window_ms});

    always_comb
    begin
        st_next      = st;
        res          = '0;
        wants_toggle = 1'b0;
        case (cmd_t'(item.cmd))
            CMD_DETENT:
            begin
                st_next.last_detent_time = item.now_ms;
                if (dir == SPIN_NONE)
                begin
                    st_next.detent_count = sum[4:0];
                end
                else
                begin
                    st_next.detent_count        = 5'sd0;
                    st_next.last_spin_direction = dir;
                    st_next.last_spin_time      = item.now_ms;
                    res.spin_seen               = dir;
                    res.resync_hit              = resync;
                    if (resync || ((dir == SPIN_RIGHT) && !st.belief_on) ||
                        ((dir == SPIN_LEFT) && st.belief_on))
                    begin
                        wants_toggle = 1'b1;
                    end
                    else
                    begin
                        res.haptic_kind = HAPTIC_FIRM;
                    end
                end
            end
            CMD_TAP:
            begin
                if (st.swallow_next_tap)
                begin
                    st_next.swallow_next_tap = 1'b0;
                end
                else
                begin
                    wants_toggle = 1'b1;
                end
            end
            CMD_LONG_PRESS:
            begin
                st_next.swallow_next_tap = 1'b1;
            end
            CMD_CLEAR:
            begin
                st_next.detent_count        = 5'sd0;
                st_next.last_detent_time    = 32'd0;
                st_next.last_spin_direction = SPIN_NONE;
                st_next.last_spin_time      = 32'd0;
                st_next.swallow_next_tap    = 1'b0;
            end
            default:
            begin
                st_next = st;
            end
        endcase

        // An accepted toggle flips the belief; turning on records the time.
        if (wants_toggle && item.link_accepts)
        begin
            st_next.belief_on = ~st.belief_on;
            if (!st.belief_on)
            begin
                st_next.start_time = item.now_ms;
            end
            res.toggle_sent = 1'b1;
            res.haptic_kind = HAPTIC_CLICK;
        end

        res.believed_live = st_next.belief_on;
        res.live_since_ms = st_next.start_time;
    end

endmodule

`default_nettype wire

### design/dial_spin_gesture_toggle.sv
// Top level of the dial spin gesture toggle: handshakes, registers and gesture state.
// An accepted word is held in the input register and its result in the result register.
// Throughput: one word per cycle unless the output stalls; the two registers sit on
// either side of one pass of compare and add logic against the gesture state.
// Reset: rst_n clears the gesture state, the belief (off) and both valid flags, and
// loads the configuration registers with 3 detents, 600 ms and 2000 ms.
`default_nettype none

module dial_spin_gesture_toggle (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic [1:0]                             cmd,
    input  wire logic signed [4:0]                      detent_delta,
    input  wire logic [31:0]                            now_ms,
    input  wire logic                                   link_accepts,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic                                        toggle_sent,
    output logic                                        believed_live,
    output logic [1:0]                                  haptic_kind,
    output logic [1:0]                                  spin_seen,
    output logic                                        resync_hit,
    output logic [31:0]                                 live_since_ms,
    input  wire logic                                   cfg_we,
    input  wire logic [dsgt_pkg::CfgIndexWidth-1:0]     cfg_index,
    input  wire logic [dsgt_pkg::CfgDataWidth-1:0]      cfg_data
);
    import dsgt_pkg::*;

    cfg_t    cfg_reg;
    item_t   in_reg;
    logic    in_valid_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t out_reg;
    result_t out_next;
    logic    out_valid_reg;
    logic    out_free;
    logic    in_take;
    logic    step_fire;

    assign out_free  = !out_valid_reg || !out_stall;
    assign step_fire = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign in_take   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.detents_per_spin <= DETENTS_PER_SPIN_RESET;
            cfg_reg.gap_limit_ms     <= GAP_LIMIT_MS_RESET;
            cfg_reg.resync_window_ms <= RESYNC_WINDOW_MS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DETENTS_PER_SPIN: cfg_reg.detents_per_spin <= cfg_data[3:0];
                CFG_GAP_LIMIT_MS:     cfg_reg.gap_limit_ms     <= cfg_data;
                CFG_RESYNC_WINDOW_MS: cfg_reg.resync_window_ms <= cfg_data;
                default:              cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_reg.cmd          <= cmd;
            in_reg.detent_delta <= detent_delta;
            in_reg.now_ms       <= now_ms;
            in_reg.link_accepts <= link_accepts;
        end
        if (step_fire)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step_fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (step_fire)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    dsgt_step u_step (
        .cfg     (cfg_reg),
        .item    (in_reg),
        .st      (state_reg),
        .st_next (state_next),
        .res     (out_next)
    );

    assign out_valid     = out_valid_reg;
    assign toggle_sent   = out_reg.toggle_sent;
    assign believed_live = out_reg.believed_live;
    assign haptic_kind   = out_reg.haptic_kind;
    assign spin_seen     = out_reg.spin_seen;
    assign resync_hit    = out_reg.resync_hit;
    assign live_since_ms = out_reg.live_since_ms;

    // The belief only moves when a word goes through the step logic.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.belief_on != $past(state_reg.belief_on)) |-> $past(step_fire))
        else $error("belief changed without a processed word");

    // A sent toggle always reports a click and the belief it produced.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.toggle_sent) |->
            (out_reg.haptic_kind == HAPTIC_CLICK) &&
            (out_reg.believed_live == state_reg.belief_on || in_valid_reg))
        else $error("sent toggle without click");

    // A resync is only reported for a real spin.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.resync_hit) |-> (out_reg.spin_seen != SPIN_NONE))
        else $error("resync reported without a spin");

    // The stored detent sum always stays below the largest threshold.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.detent_count >= -5'sd14) && (state_reg.detent_count <= 5'sd14))
        else $error("detent sum out of range");

endmodule

`default_nettype wire

### verif/dial_spin_gesture_toggle_tb.sv
// Self-checking testbench for the dial spin gesture toggle block.
`timescale 1ns / 1ps

module dial_spin_gesture_toggle_tb;

    import dsgt_pkg::*;

    class gesture_tracker;
        logic [3:0]  detents_per_spin;
        logic [15:0] gap_limit;
        logic [15:0] resync_window;
        int          detent_sum;
        logic [31:0] last_detent_ms;
        spin_t       last_spin;
        logic [31:0] last_spin_ms;
        logic        belief_on;
        logic [31:0] live_since;
        logic        swallow_tap;
        result_t     outcome_q[$];
        int          words_noted;
        int          results_checked;
        int          mismatches;
        int          spins;
        int          toggles;

        function new();
            detents_per_spin = DETENTS_PER_SPIN_RESET;
            gap_limit        = GAP_LIMIT_MS_RESET;
            resync_window    = RESYNC_WINDOW_MS_RESET;
            detent_sum       = 0;
            last_detent_ms   = '0;
            last_spin        = SPIN_NONE;
            last_spin_ms     = '0;
            belief_on        = 1'b0;
            live_since       = '0;
            swallow_tap      = 1'b0;
            words_noted      = 0;
            results_checked  = 0;
            mismatches       = 0;
            spins            = 0;
            toggles          = 0;
        endfunction

        function void set_reg(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
            if (idx == CFG_DETENTS_PER_SPIN)
                detents_per_spin = data[3:0];
            else if (idx == CFG_GAP_LIMIT_MS)
                gap_limit = data;
            else if (idx == CFG_RESYNC_WINDOW_MS)
                resync_window = data;
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction

        function void note_word(item_t w);
            result_t     r;
            int          thr;
            int          delta;
            int          sum;
            spin_t       dir;
            logic        want_toggle;
            logic [31:0] since;
            r = '0;
            dir = SPIN_NONE;
            want_toggle = 1'b0;
            delta = $signed(w.detent_delta);
            words_noted++;
            case (cmd_t'(w.cmd))
                CMD_DETENT:
                begin
                    thr = (detents_per_spin == 4'd0) ? 1 : int'(detents_per_spin);
                    since = w.now_ms - last_detent_ms;
                    if (since > {16'd0, gap_limit})
                        detent_sum = 0;
                    last_detent_ms = w.now_ms;
                    if ((detent_sum > 0 && delta < 0) || (detent_sum < 0 && delta > 0))
                        detent_sum = 0;
                    sum = detent_sum + delta;
                    if (sum >= thr)
                    begin
                        detent_sum = 0;
                        dir = SPIN_RIGHT;
                    end
                    else if (sum <= -thr)
                    begin
                        detent_sum = 0;
                        dir = SPIN_LEFT;
                    end
                    else
                        detent_sum = sum;
                    if (dir != SPIN_NONE)
                    begin
                        spins++;
                        since = w.now_ms - last_spin_ms;
                        r.resync_hit = (dir == last_spin) && (since < {16'd0, resync_window});
                        last_spin = dir;
                        last_spin_ms = w.now_ms;
                        r.spin_seen = dir;
                        if (r.resync_hit || (dir == SPIN_RIGHT && !belief_on) ||
                            (dir == SPIN_LEFT && belief_on))
                            want_toggle = 1'b1;
                        else
                            r.haptic_kind = HAPTIC_FIRM;
                    end
                end
                CMD_TAP:
                begin
                    if (swallow_tap)
                        swallow_tap = 1'b0;
                    else
                        want_toggle = 1'b1;
                end
                CMD_LONG_PRESS:
                    swallow_tap = 1'b1;
                default:
                begin
                    detent_sum = 0;
                    last_detent_ms = '0;
                    last_spin = SPIN_NONE;
                    last_spin_ms = '0;
                    swallow_tap = 1'b0;
                end
            endcase
            if (want_toggle && w.link_accepts)
            begin
                belief_on = !belief_on;
                if (belief_on)
                    live_since = w.now_ms;
                r.toggle_sent = 1'b1;
                r.haptic_kind = HAPTIC_CLICK;
                toggles++;
            end
            r.believed_live = belief_on;
            r.live_since_ms = live_since;
            outcome_q.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t exp;
            if (outcome_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result arrived with no word waiting: %p", $time, got);
                return;
            end
            exp = outcome_q.pop_front();
            results_checked++;
            if (got.toggle_sent !== exp.toggle_sent || got.believed_live !== exp.believed_live ||
                got.haptic_kind !== exp.haptic_kind || got.spin_seen !== exp.spin_seen ||
                got.resync_hit !== exp.resync_hit || got.live_since_ms !== exp.live_since_ms)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch on result %0d: expected sent=%b live=%b haptic=%0d spin=%0d resync=%b since=%h, got sent=%b live=%b haptic=%0d spin=%0d resync=%b since=%h",
                             $time, results_checked, exp.toggle_sent, exp.believed_live,
                             exp.haptic_kind, exp.spin_seen, exp.resync_hit, exp.live_since_ms,
                             got.toggle_sent, got.believed_live, got.haptic_kind, got.spin_seen,
                             got.resync_hit, got.live_since_ms);
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [1:0]               cmd;
    logic signed [4:0]        detent_delta;
    logic [31:0]              now_ms;
    logic                     link_accepts;
    logic                     out_valid;
    logic                     out_stall;
    logic                     toggle_sent;
    logic                     believed_live;
    logic [1:0]               haptic_kind;
    logic [1:0]               spin_seen;
    logic                     resync_hit;
    logic [31:0]              live_since_ms;
    logic                     cfg_we;
    logic [CfgIndexWidth-1:0] cfg_index;
    logic [CfgDataWidth-1:0]  cfg_data;

    gesture_tracker sb;
    logic [31:0]    clock_ms = '0;
    int             step_ms_max = 100;
    int             turn_dir = 1;
    int             rx_hold_cycles = 0;
    int             settings_run = 1;
    bit             idling = 1'b1;

    dial_spin_gesture_toggle u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .detent_delta  (detent_delta),
        .now_ms        (now_ms),
        .link_accepts  (link_accepts),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .toggle_sent   (toggle_sent),
        .believed_live (believed_live),
        .haptic_kind   (haptic_kind),
        .spin_seen     (spin_seen),
        .resync_hit    (resync_hit),
        .live_since_ms (live_since_ms),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("[dial_spin_gesture_toggle] ERROR");
        $finish;
    end

    // The receiver stalls in random bursts while idling is set, or for one long stretch when asked.
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
                out_stall <= 1'b0;
            end
            else if (idling && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(result_t'{toggle_sent, believed_live, haptic_t'(haptic_kind),
                                      spin_t'(spin_seen), resync_hit, live_since_ms});
    end

    task automatic send_word(item_t w);
        in_valid     <= 1'b1;
        cmd          <= w.cmd;
        detent_delta <= w.detent_delta;
        now_ms       <= w.now_ms;
        link_accepts <= w.link_accepts;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_word(w);
    endtask

    task automatic send_event(cmd_t c, int d, logic [31:0] t, logic acc);
        item_t w;
        w.cmd = c;
        w.detent_delta = d[4:0];
        w.now_ms = t;
        w.link_accepts = acc;
        send_word(w);
    endtask

    task automatic pause_input(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic load_settings(logic [3:0] dps, logic [15:0] gap, logic [15:0] win);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DETENTS_PER_SPIN;
        cfg_data  <= {12'd0, dps};
        @(posedge clk);
        cfg_index <= CFG_GAP_LIMIT_MS;
        cfg_data  <= gap;
        @(posedge clk);
        cfg_index <= CFG_RESYNC_WINDOW_MS;
        cfg_data  <= win;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_reg(CFG_DETENTS_PER_SPIN, {12'd0, dps});
        sb.set_reg(CFG_GAP_LIMIT_MS, gap);
        sb.set_reg(CFG_RESYNC_WINDOW_MS, win);
    endtask

    // Most words keep turning one way at a modest pace so that spins and resyncs occur.
    task automatic next_word(output item_t w);
        int pick;
        int d;
        case ($urandom_range(0, 39))
            0: clock_ms = $urandom;
            1: clock_ms = clock_ms + sb.gap_limit + $urandom_range(0, 1);
            2: clock_ms = sb.last_spin_ms + sb.resync_window - $urandom_range(0, 1);
            3, 4, 5: ;
            default: clock_ms = clock_ms + $urandom_range(1, step_ms_max);
        endcase
        if ($urandom_range(0, 9) == 0)
            turn_dir = -turn_dir;
        pick = $urandom_range(0, 99);
        if (pick < 72)
            d = turn_dir * int'($urandom_range(1, 3));
        else if (pick < 82)
            d = -turn_dir * int'($urandom_range(1, 2));
        else if (pick < 87)
            d = 0;
        else if (pick < 93)
            d = turn_dir * 8;
        else
            d = int'($urandom_range(0, 31)) - 16;
        w.detent_delta = d[4:0];
        pick = $urandom_range(0, 99);
        if (pick < 78)
            w.cmd = CMD_DETENT;
        else if (pick < 89)
            w.cmd = CMD_TAP;
        else if (pick < 96)
            w.cmd = CMD_LONG_PRESS;
        else
            w.cmd = CMD_CLEAR;
        w.now_ms = clock_ms;
        w.link_accepts = ($urandom_range(0, 6) != 0);
    endtask

    task automatic run_phase(logic [3:0] dps, logic [15:0] gap, logic [15:0] win, int step,
                             logic [31:0] first_ms, int count, int hold_at);
        item_t w;
        load_settings(dps, gap, win);
        settings_run++;
        clock_ms = first_ms;
        step_ms_max = step;
        for (int i = 0; i < count; i++)
        begin
            if (i == hold_at)
                rx_hold_cycles = 80;
            next_word(w);
            send_word(w);
            if (idling && $urandom_range(0, 5) == 0)
                pause_input($urandom_range(1, 12));
        end
        settle();
    endtask

    initial
    begin
        sb = new();
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        cmd          <= CMD_DETENT;
        detent_delta <= '0;
        now_ms       <= '0;
        link_accepts <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_DETENTS_PER_SPIN;
        cfg_data     <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_event(CMD_DETENT, 1, 1000, 1'b1);
        send_event(CMD_DETENT, 1, 1100, 1'b1);
        send_event(CMD_DETENT, 1, 1200, 1'b1);
        send_event(CMD_DETENT, 3, 1300, 1'b1);
        send_event(CMD_DETENT, -8, 1400, 1'b1);
        send_event(CMD_DETENT, -8, 1500, 1'b0);
        send_event(CMD_DETENT, 8, 1600, 1'b1);
        send_event(CMD_DETENT, 0, 5000, 1'b1);
        send_event(CMD_DETENT, 2, 5100, 1'b1);
        send_event(CMD_DETENT, -1, 5200, 1'b1);
        send_event(CMD_DETENT, -2, 5300, 1'b1);
        send_event(CMD_DETENT, 2, 6000, 1'b1);
        send_event(CMD_DETENT, 1, 6601, 1'b1);
        send_event(CMD_DETENT, 2, 7201, 1'b1);
        send_event(CMD_LONG_PRESS, 0, 7300, 1'b1);
        send_event(CMD_TAP, 0, 7400, 1'b1);
        send_event(CMD_TAP, 0, 7500, 1'b1);
        send_event(CMD_TAP, 0, 7600, 1'b0);
        send_event(CMD_LONG_PRESS, 0, 7700, 1'b1);
        send_event(CMD_CLEAR, 0, 7800, 1'b1);
        send_event(CMD_TAP, 0, 7900, 1'b1);
        send_event(CMD_DETENT, 15, 32'hFFFF_FFF0, 1'b1);
        send_event(CMD_DETENT, -16, 32'h0000_0010, 1'b1);
        send_event(CMD_DETENT, 7, 32'hFFFF_FFFF, 1'b1);
        send_event(CMD_DETENT, 7, 32'h0000_0000, 1'b1);
        settle();

        run_phase(4'd3, 16'd600, 16'd2000, 250, 32'd1000, 155, 40);
        run_phase(4'd1, 16'd0, 16'd0, 2, 32'd0, 155, -1);
        run_phase(4'd15, 16'hFFFF, 16'hFFFF, 400, $urandom, 155, -1);
        run_phase(4'd0, 16'd300, 16'd1000, 200, 32'hFFFF_F000, 155, -1);
        run_phase(4'd5, 16'd1000, 16'd4000, 300, 32'd5000, 155, -1);
        run_phase(4'd2, 16'hFFFF, 16'd0, 500, 32'd0, 155, -1);
        idling = 1'b0;
        run_phase(4'd4, 16'd800, 16'hFFFF, 300, 32'd100000, 155, -1);
        repeat (5) @(posedge clk);

        $display("Ran %0d words through %0d register settings: %0d spins, %0d accepted toggles.",
                 sb.words_noted, settings_run, sb.spins, sb.toggles);
        $display("Compared %0d results, %0d mismatches.", sb.results_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[dial_spin_gesture_toggle] OK");
        else
            $display("[dial_spin_gesture_toggle] ERROR");
        $finish;
    end

endmodule
